// File: hw/rtl/ebi_pkg.sv
// Shared types, constants and saturating helpers for the Euler body integrator.
`timescale 1ns / 1ps
package ebi_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DtW    = 16;
  localparam int unsigned OpW    = 3;
  localparam int unsigned DragW  = 31;
  localparam int unsigned AddrW  = 4;

  // request opcodes
  localparam logic [OpW-1:0] OP_TICK     = 3'd0;
  localparam logic [OpW-1:0] OP_PREDICT  = 3'd1;
  localparam logic [OpW-1:0] OP_LOAD_VEL = 3'd2;
  localparam logic [OpW-1:0] OP_LOAD_ACC = 3'd3;
  localparam logic [OpW-1:0] OP_LOAD_POS = 3'd4;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_GRAVITY  = 2'd0;
  localparam logic [1:0] REG_TERMINAL = 2'd1;
  localparam logic [1:0] REG_DRAG     = 2'd2;
  localparam logic [1:0] REG_WIND     = 2'd3;

  // configuration reset values
  localparam logic signed [DataW-1:0] GRAVITY_RESET  = -32'sd642253;
  localparam logic signed [DataW-1:0] TERMINAL_RESET = -32'sd3276800;
  localparam logic [DragW-1:0]        DRAG_RESET     = 31'd327680;
  localparam logic signed [DataW-1:0] WIND_RESET     = 32'sd0;

  // operand fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_ACC_X,
    MUL_ACC_Y,
    MUL_GRAV,
    MUL_WIND,
    MUL_DRAG,
    MUL_VEL_X,
    MUL_VEL_Y
  } mul_sel_t;

  // how the registered product is folded into the working copies
  typedef enum logic [2:0] {
    APL_NONE,
    APL_VEL_X,
    APL_VEL_Y,
    APL_ACC_Y,
    APL_ACC_X,
    APL_DRAG,
    APL_POS_X,
    APL_POS_Y
  } apply_sel_t;

  typedef struct packed {
    logic       start;
    mul_sel_t   mul_sel;
    apply_sel_t apply_sel;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] gravity_rate;
    logic signed [DataW-1:0] terminal_speed;
    logic [DragW-1:0]        ground_drag;
    logic signed [DataW-1:0] wind_power;
  } cfg_t;

  // clip a 33-bit sum to the signed 32-bit range
  function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] v);
    logic signed [DataW-1:0] r;
    if (v[DataW] != v[DataW-1]) begin
      r = v[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat_add(input logic signed [DataW-1:0] a,
                                                      input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    return sat33(s);
  endfunction

  function automatic logic signed [DataW-1:0] sat_sub(input logic signed [DataW-1:0] a,
                                                      input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    return sat33(s);
  endfunction

endpackage

// File: hw/rtl/ebi_cfg_regs.sv
// APB-style configuration registers: gravity, terminal speed, drag and wind.
`timescale 1ns / 1ps
module ebi_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ebi_pkg::AddrW-1:0]  paddr,
  input  logic [ebi_pkg::DataW-1:0]  pwdata,
  output logic [ebi_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output ebi_pkg::cfg_t              cfg
);

  ebi_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_rate   <= ebi_pkg::GRAVITY_RESET;
      cfg_r.terminal_speed <= ebi_pkg::TERMINAL_RESET;
      cfg_r.ground_drag    <= ebi_pkg::DRAG_RESET;
      cfg_r.wind_power     <= ebi_pkg::WIND_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        ebi_pkg::REG_GRAVITY:  cfg_r.gravity_rate   <= pwdata;
        ebi_pkg::REG_TERMINAL: cfg_r.terminal_speed <= pwdata;
        ebi_pkg::REG_DRAG:     cfg_r.ground_drag    <= pwdata[ebi_pkg::DragW-1:0];
        ebi_pkg::REG_WIND:     cfg_r.wind_power     <= pwdata;
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (reg_idx)
      ebi_pkg::REG_GRAVITY:  prdata = cfg_r.gravity_rate;
      ebi_pkg::REG_TERMINAL: prdata = cfg_r.terminal_speed;
      ebi_pkg::REG_DRAG:     prdata = {1'b0, cfg_r.ground_drag};
      ebi_pkg::REG_WIND:     prdata = cfg_r.wind_power;
      default:               prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/ebi_ctrl.sv
// Sequencer: walks the multiply/apply steps of a tick or predict request.
`timescale 1ns / 1ps
module ebi_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ebi_pkg::OpW-1:0]   in_opcode,
  input  logic                      in_on_ground,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ebi_pkg::cmd_t             cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7,
    S_G1, S_G2, S_G3, S_G4, S_G5,
    S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;
  logic   integrate;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign integrate = (in_opcode == ebi_pkg::OP_TICK) || (in_opcode == ebi_pkg::OP_PREDICT);

  // per-step commands; the apply code always refers to the product issued in the previous state
  always_comb begin
    cmd.start     = accept;
    cmd.finish    = (state_r == S_FIN) && (!out_valid_r || out_ready);
    cmd.mul_sel   = ebi_pkg::MUL_ACC_X;
    cmd.apply_sel = ebi_pkg::APL_NONE;
    case (state_r)
      S_A1: begin
        cmd.mul_sel = ebi_pkg::MUL_ACC_X;
      end
      S_A2: begin
        cmd.mul_sel   = ebi_pkg::MUL_ACC_Y;
        cmd.apply_sel = ebi_pkg::APL_VEL_X;
      end
      S_A3: begin
        cmd.mul_sel   = ebi_pkg::MUL_GRAV;
        cmd.apply_sel = ebi_pkg::APL_VEL_Y;
      end
      S_A4: begin
        cmd.mul_sel   = ebi_pkg::MUL_WIND;
        cmd.apply_sel = ebi_pkg::APL_ACC_Y;
      end
      S_A5: begin
        cmd.mul_sel   = ebi_pkg::MUL_VEL_X;
        cmd.apply_sel = ebi_pkg::APL_ACC_X;
      end
      S_A6: begin
        cmd.mul_sel   = ebi_pkg::MUL_VEL_Y;
        cmd.apply_sel = ebi_pkg::APL_POS_X;
      end
      S_A7: begin
        cmd.apply_sel = ebi_pkg::APL_POS_Y;
      end
      S_G1: begin
        cmd.mul_sel = ebi_pkg::MUL_ACC_X;
      end
      S_G2: begin
        cmd.mul_sel   = ebi_pkg::MUL_DRAG;
        cmd.apply_sel = ebi_pkg::APL_VEL_X;
      end
      S_G3: begin
        cmd.apply_sel = ebi_pkg::APL_DRAG;
      end
      S_G4: begin
        cmd.mul_sel = ebi_pkg::MUL_VEL_X;
      end
      S_G5: begin
        cmd.apply_sel = ebi_pkg::APL_POS_X;
      end
      default: ;
    endcase
  end

  // state and result-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!integrate) begin
              state_r <= S_FIN;
            end else if (in_on_ground) begin
              state_r <= S_G1;
            end else begin
              state_r <= S_A1;
            end
          end
        end
        S_A1: state_r <= S_A2;
        S_A2: state_r <= S_A3;
        S_A3: state_r <= S_A4;
        S_A4: state_r <= S_A5;
        S_A5: state_r <= S_A6;
        S_A6: state_r <= S_A7;
        S_A7: state_r <= S_FIN;
        S_G1: state_r <= S_G2;
        S_G2: state_r <= S_G3;
        S_G3: state_r <= S_G4;
        S_G4: state_r <= S_G5;
        S_G5: state_r <= S_FIN;
        S_FIN: begin
          if (cmd.finish) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/ebi_datapath.sv
// Datapath: body state, working copies, shared rate*dt multiplier and result register.
`timescale 1ns / 1ps
module ebi_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ebi_pkg::cmd_t                     cmd,
  input  ebi_pkg::cfg_t                     cfg,
  input  logic [ebi_pkg::OpW-1:0]           in_opcode,
  input  logic [ebi_pkg::DtW-1:0]           in_delta_time,
  input  logic signed [ebi_pkg::DataW-1:0]  in_value_x,
  input  logic signed [ebi_pkg::DataW-1:0]  in_value_y,
  output logic signed [ebi_pkg::DataW-1:0]  out_pos_x,
  output logic signed [ebi_pkg::DataW-1:0]  out_pos_y,
  output logic signed [ebi_pkg::DataW-1:0]  out_vel_x,
  output logic signed [ebi_pkg::DataW-1:0]  out_vel_y,
  output logic signed [ebi_pkg::DataW-1:0]  out_acc_x,
  output logic signed [ebi_pkg::DataW-1:0]  out_acc_y
);

  localparam int unsigned W = ebi_pkg::DataW;
  localparam int unsigned D = ebi_pkg::DtW;

  // held body state
  logic signed [W-1:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, acc_x_r, acc_y_r;
  logic signed [W-1:0] pos_x_nxt, pos_y_nxt, vel_x_nxt, vel_y_nxt, acc_x_nxt, acc_y_nxt;
  // working copies for the request in flight
  logic signed [W-1:0] wpx_r, wpy_r, wvx_r, wvy_r, wax_r, way_r;
  // captured request
  logic [ebi_pkg::OpW-1:0] op_r;
  logic [D-1:0]            dt_r;
  logic signed [W-1:0]     val_x_r, val_y_r;
  // multiplier
  logic signed [W-1:0]     mul_a;
  logic signed [W+D:0]     prod;
  logic signed [W-1:0]     scaled_r;
  // result register
  logic signed [W-1:0] res_px_r, res_py_r, res_vx_r, res_vy_r, res_ax_r, res_ay_r;
  // apply helpers
  logic signed [W-1:0] vy_sum;
  logic signed [W:0]   drag_up, drag_down;
  logic signed [W-1:0] drag_vx;

  // operand select and one shared multiplier; product floored to Q16.16
  always_comb begin
    case (cmd.mul_sel)
      ebi_pkg::MUL_ACC_X: mul_a = wax_r;
      ebi_pkg::MUL_ACC_Y: mul_a = way_r;
      ebi_pkg::MUL_GRAV:  mul_a = cfg.gravity_rate;
      ebi_pkg::MUL_WIND:  mul_a = cfg.wind_power;
      ebi_pkg::MUL_DRAG:  mul_a = {1'b0, cfg.ground_drag};
      ebi_pkg::MUL_VEL_X: mul_a = wvx_r;
      ebi_pkg::MUL_VEL_Y: mul_a = wvy_r;
      default:            mul_a = '0;
    endcase
  end

  assign prod = mul_a * $signed({1'b0, dt_r});

  always_ff @(posedge clk) begin
    scaled_r <= prod[W+D-1:D];
  end

  // saturated vertical velocity sum; the terminal clamp is applied when it is written back
  assign vy_sum = ebi_pkg::sat_add(wvy_r, scaled_r);

  // ground drag toward zero, never crossing it
  assign drag_up   = {wvx_r[W-1], wvx_r} + {scaled_r[W-1], scaled_r};
  assign drag_down = {wvx_r[W-1], wvx_r} - {scaled_r[W-1], scaled_r};

  always_comb begin
    if (wvx_r[W-1]) begin
      drag_vx = (drag_up > 0) ? '0 : drag_up[W-1:0];
    end else if (wvx_r != 0) begin
      drag_vx = (drag_down < 0) ? '0 : drag_down[W-1:0];
    end else begin
      drag_vx = wvx_r;
    end
  end

  // capture request and update working copies
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_opcode;
      dt_r    <= in_delta_time;
      val_x_r <= in_value_x;
      val_y_r <= in_value_y;
      wpx_r   <= pos_x_r;
      wpy_r   <= pos_y_r;
      wvx_r   <= vel_x_r;
      wvy_r   <= vel_y_r;
      wax_r   <= acc_x_r;
      way_r   <= acc_y_r;
    end else begin
      case (cmd.apply_sel)
        ebi_pkg::APL_VEL_X: wvx_r <= ebi_pkg::sat_add(wvx_r, scaled_r);
        ebi_pkg::APL_VEL_Y: wvy_r <= (vy_sum < cfg.terminal_speed) ? cfg.terminal_speed : vy_sum;
        ebi_pkg::APL_ACC_Y: way_r <= ebi_pkg::sat_add(way_r, scaled_r);
        ebi_pkg::APL_ACC_X: wax_r <= ebi_pkg::sat_sub(wax_r, scaled_r);
        ebi_pkg::APL_DRAG: begin
          if (wax_r == 0) begin
            wvx_r <= drag_vx;
          end
          wvy_r <= '0;
          way_r <= '0;
        end
        ebi_pkg::APL_POS_X: wpx_r <= ebi_pkg::sat_add(wpx_r, scaled_r);
        ebi_pkg::APL_POS_Y: wpy_r <= ebi_pkg::sat_add(wpy_r, scaled_r);
        default: ;
      endcase
    end
  end

  // state after the request
  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    vel_x_nxt = vel_x_r;
    vel_y_nxt = vel_y_r;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    case (op_r)
      ebi_pkg::OP_TICK: begin
        pos_x_nxt = wpx_r;
        pos_y_nxt = wpy_r;
        vel_x_nxt = wvx_r;
        vel_y_nxt = wvy_r;
        acc_x_nxt = wax_r;
        acc_y_nxt = way_r;
      end
      ebi_pkg::OP_LOAD_VEL: begin
        vel_x_nxt = val_x_r;
        vel_y_nxt = val_y_r;
      end
      ebi_pkg::OP_LOAD_ACC: begin
        acc_x_nxt = val_x_r;
        acc_y_nxt = val_y_r;
      end
      ebi_pkg::OP_LOAD_POS: begin
        pos_x_nxt = val_x_r;
        pos_y_nxt = val_y_r;
      end
      default: ;
    endcase
  end

  // commit state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (cmd.finish) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      vel_x_r <= vel_x_nxt;
      vel_y_r <= vel_y_nxt;
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  // result register; predict reports the integrated position only
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_px_r <= (op_r == ebi_pkg::OP_PREDICT) ? wpx_r : pos_x_nxt;
      res_py_r <= (op_r == ebi_pkg::OP_PREDICT) ? wpy_r : pos_y_nxt;
      res_vx_r <= vel_x_nxt;
      res_vy_r <= vel_y_nxt;
      res_ax_r <= acc_x_nxt;
      res_ay_r <= acc_y_nxt;
    end
  end

  assign out_pos_x = res_px_r;
  assign out_pos_y = res_py_r;
  assign out_vel_x = res_vx_r;
  assign out_vel_y = res_vy_r;
  assign out_acc_x = res_ax_r;
  assign out_acc_y = res_ay_r;

endmodule

// File: hw/rtl/euler_body_integrator_unit.sv
// Tick/predict walks the multiply/apply states A1-A7 (airborne) or G1-G5 (grounded), then FIN;
// loads go straight to FIN. A new request is taken only once the last one is through, and
// every rate*dt product goes through the single shared 32x17 multiplier in turn.
// A request is taken while the previous result still waits in the output register.
// Reset (synchronous, rst_n low): body state cleared, configuration to defaults, no result.
`timescale 1ns / 1ps
module euler_body_integrator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ebi_pkg::OpW-1:0]           in_opcode,
  input  logic [ebi_pkg::DtW-1:0]           in_delta_time,
  input  logic                              in_on_ground,
  input  logic signed [ebi_pkg::DataW-1:0]  in_value_x,
  input  logic signed [ebi_pkg::DataW-1:0]  in_value_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ebi_pkg::DataW-1:0]  out_pos_x,
  output logic signed [ebi_pkg::DataW-1:0]  out_pos_y,
  output logic signed [ebi_pkg::DataW-1:0]  out_vel_x,
  output logic signed [ebi_pkg::DataW-1:0]  out_vel_y,
  output logic signed [ebi_pkg::DataW-1:0]  out_acc_x,
  output logic signed [ebi_pkg::DataW-1:0]  out_acc_y,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ebi_pkg::AddrW-1:0]         paddr,
  input  logic [ebi_pkg::DataW-1:0]         pwdata,
  output logic [ebi_pkg::DataW-1:0]         prdata,
  output logic                              pready
);

  ebi_pkg::cmd_t cmd;
  ebi_pkg::cfg_t cfg;

  // configuration registers
  ebi_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  ebi_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_opcode    (in_opcode),
    .in_on_ground (in_on_ground),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  // arithmetic and state
  ebi_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg           (cfg),
    .in_opcode     (in_opcode),
    .in_delta_time (in_delta_time),
    .in_value_x    (in_value_x),
    .in_value_y    (in_value_y),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_vel_x     (out_vel_x),
    .out_vel_y     (out_vel_y),
    .out_acc_x     (out_acc_x),
    .out_acc_y     (out_acc_y)
  );

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // a result appears only at the end of a request in flight
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised with no request in flight");

  // the datapath captures only on an accepted request
  a_start_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (in_valid && in_ready))
    else $error("capture without an accepted request");

  // finishing never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule
